// ----- hdl/bile_pkg.sv -----
// shared types and constants of the bounded indexed list engine
// no dependencies; every other file of the block refers to it by scoped names
package bile_pkg;

    localparam int CAPACITY_ENTRIES = 16;
    localparam int VALUE_WIDTH      = 32;

    // fixed widths of the request and response fields
    localparam int MODE_W  = 4;
    localparam int POS_W   = 5;
    localparam int ITEM_W  = 32;
    localparam int FIELD_W = 5;

    // list indexing and fill count
    localparam int IDX_W = $clog2(CAPACITY_ENTRIES);
    localparam int CNT_W = $clog2(CAPACITY_ENTRIES + 1);
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT_AT    = 4'd0,
        MODE_INSERT_FRONT = 4'd1,
        MODE_INSERT_BACK  = 4'd2,
        MODE_REMOVE_AT    = 4'd3,
        MODE_REMOVE_FRONT = 4'd4,
        MODE_REMOVE_BACK  = 4'd5,
        MODE_SELECT       = 4'd6,
        MODE_SEARCH       = 4'd7,
        MODE_REPLACE      = 4'd8
    } mode_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// ----- hdl/bile_cmd_if.sv -----
// request channel of the list engine: valid/ready plus mode, position, item
// depends on bile_pkg
interface bile_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [bile_pkg::MODE_W-1:0]         mode;
    logic [bile_pkg::POS_W-1:0]          position;
    logic signed [bile_pkg::ITEM_W-1:0]  item;

    modport source (output valid, output mode, output position, output item, input ready);
    modport sink   (input valid, input mode, input position, input item, output ready);
endinterface

// ----- hdl/bile_rsp_if.sv -----
// response channel of the list engine: valid/ready plus result fields
// depends on bile_pkg
interface bile_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                ok;
    logic signed [bile_pkg::ITEM_W-1:0]  read_value;
    logic [bile_pkg::FIELD_W-1:0]        found_at;
    logic [bile_pkg::FIELD_W-1:0]        count;
    logic                                is_empty;
    logic                                is_full;

    modport source (output valid, output ok, output read_value, output found_at,
                    output count, output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input read_value, input found_at,
                    input count, input is_empty, input is_full, output ready);
endinterface

// ----- hdl/bounded_indexed_list_engine.sv -----
// channel | dir | handshake   | payload
// cmd     | in  | valid/ready | mode[3:0], position[4:0], item[31:0]
// rsp     | out | valid/ready | ok, read_value[31:0], found_at[4:0], count[4:0],
//         |     |             | is_empty, is_full
//
// a request is registered when accepted and executed against all entries in parallel
// once the response register is free, which then registers its response; with rsp
// drained, one request per cycle is sustained
// the response register is the only limit: a stalled rsp holds the next request
// in the command register and deasserts cmd.ready
// rst_n clears the fill count and the response valid; entry contents are unset
// top level of the list engine; depends on bile_pkg, bile_cmd_if, bile_rsp_if,
// bile_ctrl and bile_dp
module bounded_indexed_list_engine (
    input  logic      clk,
    input  logic      rst_n,
    bile_cmd_if.sink  cmd,
    bile_rsp_if.source rsp
);

    bile_pkg::ctrl_cmd_t  ctrl;
    bile_pkg::dp_status_t status;

    bile_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .status    (status),
        .ctrl      (ctrl)
    );

    bile_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .status     (status),
        .mode       (cmd.mode),
        .position   (cmd.position),
        .item       (cmd.item),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .ok         (rsp.ok),
        .read_value (rsp.read_value),
        .found_at   (rsp.found_at),
        .count      (rsp.count),
        .is_empty   (rsp.is_empty),
        .is_full    (rsp.is_full)
    );

endmodule

// ----- hdl/bile_ctrl.sv -----
// controller of the list engine: takes requests, sequences execution
// depends on bile_pkg
module bile_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  bile_pkg::dp_status_t status,
    output bile_pkg::ctrl_cmd_t  ctrl
);

    bile_pkg::ctrl_state_t state_reg;
    bile_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bile_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_ready  = 1'b0;
        ctrl       = '0;
        unique case (state_reg)
            bile_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = bile_pkg::ST_EXEC;
                end
            end
            bile_pkg::ST_EXEC:
            begin
                // run the held request once the response register can take it
                if (status.out_free)
                begin
                    ctrl.exec = 1'b1;
                    cmd_ready = 1'b1;
                    if (cmd_valid)
                    begin
                        ctrl.load = 1'b1;
                    end
                    else
                    begin
                        state_next = bile_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = bile_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/bile_dp.sv -----
// datapath of the list engine: entry registers, shift network, search,
// select and the response register; depends on bile_pkg
module bile_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bile_pkg::ctrl_cmd_t                 ctrl,
    output bile_pkg::dp_status_t                status,
    input  logic [bile_pkg::MODE_W-1:0]         mode,
    input  logic [bile_pkg::POS_W-1:0]          position,
    input  logic signed [bile_pkg::ITEM_W-1:0]  item,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic                                ok,
    output logic signed [bile_pkg::ITEM_W-1:0]  read_value,
    output logic [bile_pkg::FIELD_W-1:0]        found_at,
    output logic [bile_pkg::FIELD_W-1:0]        count,
    output logic                                is_empty,
    output logic                                is_full
);

    // held request
    bile_pkg::mode_t                 mode_reg;
    logic [bile_pkg::POS_W-1:0]      pos_reg;
    bile_pkg::value_t                item_reg;

    // list storage
    bile_pkg::value_t                entries_reg [bile_pkg::CAPACITY_ENTRIES];
    bile_pkg::value_t                entries_next [bile_pkg::CAPACITY_ENTRIES];
    logic [bile_pkg::CNT_W-1:0]      count_reg;
    logic [bile_pkg::CNT_W-1:0]      count_next;

    // response register
    logic                            out_valid_reg;
    logic                            ok_reg;
    bile_pkg::value_t                rd_reg;
    logic [bile_pkg::CNT_W-1:0]      found_reg;
    logic [bile_pkg::CNT_W-1:0]      cnt_out_reg;

    logic                            ok_next;
    bile_pkg::value_t                rd_next;
    logic [bile_pkg::CNT_W-1:0]      found_next;

    logic                            do_ins;
    logic                            do_rm;
    logic [bile_pkg::CMP_W-1:0]      ins_idx;
    logic [bile_pkg::CMP_W-1:0]      rm_idx;
    logic [bile_pkg::CMP_W-1:0]      cnt_x;
    logic [bile_pkg::CMP_W-1:0]      pos_x;
    logic [bile_pkg::CMP_W-1:0]      sel_idx;
    logic                            not_full;
    logic                            not_empty;

    assign status.out_free = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            mode_reg <= bile_pkg::mode_t'(mode);
            pos_reg  <= position;
            item_reg <= bile_pkg::VALUE_WIDTH'(item);
        end
        for (int k = 0; k < bile_pkg::CAPACITY_ENTRIES; k++)
        begin
            entries_reg[k] <= entries_next[k];
        end
        if (ctrl.exec)
        begin
            ok_reg      <= ok_next;
            rd_reg      <= rd_next;
            found_reg   <= found_next;
            cnt_out_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (ctrl.exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        cnt_x      = bile_pkg::CMP_W'(count_reg);
        pos_x      = bile_pkg::CMP_W'(pos_reg);
        not_full   = (count_reg != bile_pkg::CNT_W'(bile_pkg::CAPACITY_ENTRIES));
        not_empty  = (count_reg != '0);
        do_ins     = 1'b0;
        do_rm      = 1'b0;
        ins_idx    = '0;
        rm_idx     = '0;
        sel_idx    = (pos_x >= cnt_x) ? cnt_x - 1'b1 : pos_x;
        ok_next    = 1'b0;
        rd_next    = '0;
        found_next = '0;
        count_next = count_reg;
        for (int k = 0; k < bile_pkg::CAPACITY_ENTRIES; k++)
        begin
            entries_next[k] = entries_reg[k];
        end

        if (ctrl.exec)
        begin
            unique case (mode_reg)
                bile_pkg::MODE_INSERT_AT:
                begin
                    ins_idx = pos_x;
                    do_ins  = not_full && (pos_x <= cnt_x);
                end
                bile_pkg::MODE_INSERT_FRONT:
                begin
                    ins_idx = '0;
                    do_ins  = not_full;
                end
                bile_pkg::MODE_INSERT_BACK:
                begin
                    ins_idx = cnt_x;
                    do_ins  = not_full;
                end
                bile_pkg::MODE_REMOVE_AT:
                begin
                    rm_idx = pos_x;
                    do_rm  = pos_x < cnt_x;
                end
                bile_pkg::MODE_REMOVE_FRONT:
                begin
                    rm_idx = '0;
                    do_rm  = not_empty;
                end
                bile_pkg::MODE_REMOVE_BACK:
                begin
                    rm_idx = cnt_x - 1'b1;
                    do_rm  = not_empty;
                end
                bile_pkg::MODE_SELECT:
                begin
                    // past-the-end index clamps to the last entry
                    if (not_empty)
                    begin
                        ok_next = 1'b1;
                        rd_next = entries_reg[sel_idx[bile_pkg::IDX_W-1:0]];
                    end
                end
                bile_pkg::MODE_SEARCH:
                begin
                    ok_next    = 1'b1;
                    found_next = count_reg;
                    // scan downward so the lowest match wins
                    for (int k = bile_pkg::CAPACITY_ENTRIES - 1; k >= 0; k--)
                    begin
                        if ((bile_pkg::CMP_W'(k) < cnt_x) && (entries_reg[k] == item_reg))
                        begin
                            found_next = bile_pkg::CNT_W'(k);
                        end
                    end
                end
                bile_pkg::MODE_REPLACE:
                begin
                    if (pos_x < cnt_x)
                    begin
                        ok_next = 1'b1;
                        entries_next[pos_reg[bile_pkg::IDX_W-1:0]] = item_reg;
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase

            if (do_ins)
            begin
                ok_next    = 1'b1;
                count_next = count_reg + 1'b1;
                for (int k = 0; k < bile_pkg::CAPACITY_ENTRIES; k++)
                begin
                    if (bile_pkg::CMP_W'(k) == ins_idx)
                    begin
                        entries_next[k] = item_reg;
                    end
                    else if ((k > 0) && (bile_pkg::CMP_W'(k) > ins_idx))
                    begin
                        entries_next[k] = entries_reg[(k > 0) ? k - 1 : 0];
                    end
                end
            end

            if (do_rm)
            begin
                ok_next    = 1'b1;
                count_next = count_reg - 1'b1;
                for (int k = 0; k < bile_pkg::CAPACITY_ENTRIES - 1; k++)
                begin
                    if (bile_pkg::CMP_W'(k) >= rm_idx)
                    begin
                        entries_next[k] = entries_reg[k + 1];
                    end
                end
            end
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign read_value = bile_pkg::ITEM_W'(rd_reg);
    assign found_at   = bile_pkg::FIELD_W'(found_reg);
    assign count      = bile_pkg::FIELD_W'(cnt_out_reg);
    assign is_empty   = (cnt_out_reg == '0);
    assign is_full    = (cnt_out_reg == bile_pkg::CNT_W'(bile_pkg::CAPACITY_ENTRIES));

endmodule

// ----- hdl/bile_checker.sv -----
// port-level checks of the list engine, attached to the top level by bind
// depends on bile_pkg
module bile_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [bile_pkg::FIELD_W-1:0]  found_at,
    input logic [bile_pkg::FIELD_W-1:0]  count,
    input logic                          is_empty,
    input logic                          is_full
);

    // a pending response is not withdrawn
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (count == '0)))
        else $error("is_empty disagrees with count");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_full == (count == bile_pkg::FIELD_W'(bile_pkg::CAPACITY_ENTRIES))))
        else $error("is_full disagrees with count");

    // search index never lies past the list end, nor the count past capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (found_at <= count)
            && (count <= bile_pkg::FIELD_W'(bile_pkg::CAPACITY_ENTRIES)))
        else $error("found_at or count out of range");

endmodule

bind bounded_indexed_list_engine bile_checker u_bile_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .found_at  (rsp.found_at),
    .count     (rsp.count),
    .is_empty  (rsp.is_empty),
    .is_full   (rsp.is_full)
);

// ----- sim/tb_bounded_indexed_list_engine.sv -----
`timescale 1ns / 100ps
// testbench of the bounded indexed list engine: directed edge cases, fill/drain runs
// and random command mixes, each response checked against an in-bench list model
// depends on bile_pkg, bile_cmd_if, bile_rsp_if and bounded_indexed_list_engine
module tb_bounded_indexed_list_engine;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 16;
    localparam logic [bile_pkg::MODE_W-1:0] MODE_UNUSED_LO = 4'd9;
    localparam logic [bile_pkg::MODE_W-1:0] MODE_UNUSED_HI = 4'd15;
    localparam bile_pkg::value_t VALUE_MAX = 32'sh7fffffff;
    localparam bile_pkg::value_t VALUE_MIN = 32'sh80000000;

    typedef struct packed {
        logic                          ok;
        bile_pkg::value_t              read_value;
        logic [bile_pkg::FIELD_W-1:0]  found_at;
        logic [bile_pkg::FIELD_W-1:0]  count;
        logic                          is_empty;
        logic                          is_full;
    } list_result_t;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   error_count;
    int   idle_pct;

    // model of the list contents, updated as each request is accepted
    bile_pkg::value_t model_entries [bile_pkg::CAPACITY_ENTRIES];
    int               model_len;
    list_result_t     pending_results [$];

    bile_cmd_if cmd_bus ();
    bile_rsp_if rsp_bus ();

    bounded_indexed_list_engine DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    function automatic logic model_put(input int idx, input bile_pkg::value_t val);
        if (model_len >= bile_pkg::CAPACITY_ENTRIES || idx > model_len)
            return 1'b0;
        for (int k = model_len; k > idx; k--)
            model_entries[k] = model_entries[k-1];
        model_entries[idx] = val;
        model_len++;
        return 1'b1;
    endfunction

    function automatic logic model_take(input int idx);
        if (model_len == 0 || idx >= model_len)
            return 1'b0;
        for (int k = idx; k + 1 < model_len; k++)
            model_entries[k] = model_entries[k+1];
        model_len--;
        return 1'b1;
    endfunction

    function automatic list_result_t apply_list_command(
        input logic [bile_pkg::MODE_W-1:0] mode,
        input logic [bile_pkg::POS_W-1:0]  pos,
        input bile_pkg::value_t            val);
        list_result_t r;
        int           p;
        int           found;
        r = '0;
        p = int'(pos);
        found = 0;
        case (mode)
            bile_pkg::MODE_INSERT_AT:    r.ok = model_put(p, val);
            bile_pkg::MODE_INSERT_FRONT: r.ok = model_put(0, val);
            bile_pkg::MODE_INSERT_BACK:  r.ok = model_put(model_len, val);
            bile_pkg::MODE_REMOVE_AT:    r.ok = model_take(p);
            bile_pkg::MODE_REMOVE_FRONT: r.ok = model_take(0);
            bile_pkg::MODE_REMOVE_BACK:
                r.ok = (model_len > 0) ? model_take(model_len - 1) : 1'b0;
            bile_pkg::MODE_SELECT:
            begin
                if (model_len > 0)
                begin
                    // index at or past the end clamps to the last entry
                    r.read_value = model_entries[(p >= model_len) ? model_len - 1 : p];
                    r.ok = 1'b1;
                end
            end
            bile_pkg::MODE_SEARCH:
            begin
                r.ok = 1'b1;
                found = model_len;
                for (int k = 0; k < model_len; k++)
                begin
                    if (model_entries[k] == val && found == model_len)
                        found = k;
                end
            end
            bile_pkg::MODE_REPLACE:
            begin
                if (p < model_len)
                begin
                    model_entries[p] = val;
                    r.ok = 1'b1;
                end
            end
            default: r.ok = 1'b0;
        endcase
        r.found_at = found[bile_pkg::FIELD_W-1:0];
        r.count    = model_len[bile_pkg::FIELD_W-1:0];
        r.is_empty = (model_len == 0);
        r.is_full  = (model_len == bile_pkg::CAPACITY_ENTRIES);
        return r;
    endfunction

    task automatic issue_request(input logic [bile_pkg::MODE_W-1:0] mode,
                                 input logic [bile_pkg::POS_W-1:0] pos,
                                 input bile_pkg::value_t val);
        @(negedge clk);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            cmd_bus.valid = 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid    = 1'b1;
        cmd_bus.mode     = mode;
        cmd_bus.position = pos;
        cmd_bus.item     = val;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        pending_results.push_back(apply_list_command(mode, pos, val));
    endtask

    // stop sending, then wait until every outstanding request has been answered
    task automatic wait_results_drained();
        @(negedge clk);
        cmd_bus.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver stalls at random, never while idling is switched off
    initial
    begin
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_bus.ready = (idle_pct == 0) || ($urandom_range(0, 99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_response
        list_result_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: response with no request outstanding, count %0d", $time,
                         rsp_bus.count);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_bus.ok !== want.ok)
                begin
                    $display("%0t: ok expected %0b actual %0b", $time, want.ok, rsp_bus.ok);
                    error_count++;
                end
                if (rsp_bus.read_value !== want.read_value)
                begin
                    $display("%0t: read_value expected %0d actual %0d", $time,
                             want.read_value, rsp_bus.read_value);
                    error_count++;
                end
                if (rsp_bus.found_at !== want.found_at)
                begin
                    $display("%0t: found_at expected %0d actual %0d", $time,
                             want.found_at, rsp_bus.found_at);
                    error_count++;
                end
                if (rsp_bus.count !== want.count)
                begin
                    $display("%0t: count expected %0d actual %0d", $time, want.count,
                             rsp_bus.count);
                    error_count++;
                end
                if (rsp_bus.is_empty !== want.is_empty)
                begin
                    $display("%0t: is_empty expected %0b actual %0b", $time, want.is_empty,
                             rsp_bus.is_empty);
                    error_count++;
                end
                if (rsp_bus.is_full !== want.is_full)
                begin
                    $display("%0t: is_full expected %0b actual %0b", $time, want.is_full,
                             rsp_bus.is_full);
                    error_count++;
                end
            end
        end
    end

    // mix of extremes, values already in the list and a small pool for duplicates
    function automatic bile_pkg::value_t pick_item();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 4))
                0: return VALUE_MAX;
                1: return VALUE_MIN;
                2: return -1;
                3: return 1;
                default: return 0;
            endcase
        end
        if (r <= 3 && model_len > 0)
            return model_entries[$urandom_range(0, model_len - 1)];
        if (r <= 5)
            return bile_pkg::value_t'($urandom_range(0, 7));
        return bile_pkg::value_t'($urandom);
    endfunction

    function automatic logic [bile_pkg::POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return bile_pkg::POS_W'($urandom_range(0, model_len));
        if (r < 9)
            return bile_pkg::POS_W'($urandom_range(0, bile_pkg::CAPACITY_ENTRIES));
        return bile_pkg::POS_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [bile_pkg::MODE_W-1:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 16) return bile_pkg::MODE_INSERT_AT;
        if (r < 24) return bile_pkg::MODE_INSERT_FRONT;
        if (r < 34) return bile_pkg::MODE_INSERT_BACK;
        if (r < 46) return bile_pkg::MODE_REMOVE_AT;
        if (r < 52) return bile_pkg::MODE_REMOVE_FRONT;
        if (r < 58) return bile_pkg::MODE_REMOVE_BACK;
        if (r < 72) return bile_pkg::MODE_SELECT;
        if (r < 86) return bile_pkg::MODE_SEARCH;
        if (r < 96) return bile_pkg::MODE_REPLACE;
        return bile_pkg::MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    endfunction

    task automatic test_empty_list();
        issue_request(bile_pkg::MODE_REMOVE_FRONT, 0, 0);
        issue_request(bile_pkg::MODE_REMOVE_BACK, 0, 0);
        issue_request(bile_pkg::MODE_REMOVE_AT, 0, 0);
        issue_request(bile_pkg::MODE_SELECT, 0, 0);
        issue_request(bile_pkg::MODE_SEARCH, 0, 0);
        issue_request(bile_pkg::MODE_REPLACE, 0, 5);
        issue_request(bile_pkg::MODE_INSERT_AT, 1, 5);
    endtask

    task automatic test_edge_values();
        issue_request(bile_pkg::MODE_INSERT_BACK, 0, VALUE_MAX);
        issue_request(bile_pkg::MODE_INSERT_FRONT, 0, VALUE_MIN);
        issue_request(bile_pkg::MODE_INSERT_AT, 1, -1);
        issue_request(bile_pkg::MODE_INSERT_AT, 3, 0);
        issue_request(bile_pkg::MODE_SELECT, 31, 0);
        issue_request(bile_pkg::MODE_SELECT, 0, 0);
    endtask

    task automatic test_search_replace();
        issue_request(bile_pkg::MODE_SEARCH, 0, -1);
        issue_request(bile_pkg::MODE_SEARCH, 0, 12345);
        issue_request(bile_pkg::MODE_REPLACE, 1, 0);
        // two zero entries now: first match wins
        issue_request(bile_pkg::MODE_SEARCH, 0, 0);
        issue_request(bile_pkg::MODE_REPLACE, 4, 7);
    endtask

    task automatic test_bad_commands();
        issue_request(bile_pkg::MODE_REMOVE_AT, 4, 0);
        issue_request(MODE_UNUSED_LO, 0, 0);
        issue_request(MODE_UNUSED_HI, 31, -1);
        issue_request(bile_pkg::MODE_REMOVE_AT, 1, 0);
        issue_request(bile_pkg::MODE_REMOVE_FRONT, 0, 0);
        issue_request(bile_pkg::MODE_REMOVE_BACK, 0, 0);
    endtask

    // drive the list to full and past it, work on the full list, then empty it and past
    task automatic test_fill_and_drain(input int rounds);
        logic [bile_pkg::MODE_W-1:0] mode;
        for (int n = 0; n < rounds; n++)
        begin
            while (model_len < bile_pkg::CAPACITY_ENTRIES)
            begin
                mode = (n % 3 == 0) ? bile_pkg::MODE_INSERT_BACK
                     : (n % 3 == 1) ? bile_pkg::MODE_INSERT_FRONT
                                    : bile_pkg::MODE_INSERT_AT;
                issue_request(mode, bile_pkg::POS_W'($urandom_range(0, model_len)),
                              pick_item());
            end
            issue_request(bile_pkg::MODE_INSERT_BACK, 0, pick_item());
            issue_request(bile_pkg::MODE_INSERT_AT, pick_position(), pick_item());
            issue_request(bile_pkg::MODE_SELECT,
                          bile_pkg::POS_W'(bile_pkg::CAPACITY_ENTRIES), 0);
            issue_request(bile_pkg::MODE_SELECT, bile_pkg::POS_W'($urandom_range(0, 31)), 0);
            issue_request(bile_pkg::MODE_SEARCH, 0, pick_item());
            issue_request(bile_pkg::MODE_REPLACE, pick_position(), pick_item());
            issue_request(bile_pkg::MODE_SEARCH, 0, pick_item());
            issue_request(bile_pkg::MODE_SELECT, pick_position(), 0);
            while (model_len > 0)
            begin
                mode = (n % 3 == 0) ? bile_pkg::MODE_REMOVE_FRONT
                     : (n % 3 == 1) ? bile_pkg::MODE_REMOVE_BACK
                                    : bile_pkg::MODE_REMOVE_AT;
                issue_request(mode, bile_pkg::POS_W'($urandom_range(0, model_len - 1)), 0);
            end
            issue_request(bile_pkg::MODE_REMOVE_BACK, 0, 0);
            issue_request(bile_pkg::MODE_SELECT, pick_position(), 0);
        end
    endtask

    task automatic test_random_mix(input int n_requests);
        for (int n = 0; n < n_requests; n++)
            issue_request(pick_mode(), pick_position(), pick_item());
    endtask

    initial
    begin
        error_count      = 0;
        idle_pct         = 20;
        model_len        = 0;
        rst_n            = 1'b0;
        cmd_bus.valid    = 1'b0;
        cmd_bus.mode     = '0;
        cmd_bus.position = '0;
        cmd_bus.item     = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_edge_values();
        test_search_replace();
        test_bad_commands();
        test_fill_and_drain(4);
        test_random_mix(500);
        // hold off new requests until the engine has answered everything
        wait_results_drained();
        idle_pct = 0;
        test_random_mix(250);
        idle_pct = 20;
        test_random_mix(150);

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
